FILE: sv/ihr_pkg.sv
// Shared types, constants and helpers for the Intel HEX record encoder.
package ihr_pkg;

  localparam int unsigned BUF_DEPTH = 16;
  localparam int unsigned BUF_AW    = 4;
  localparam int unsigned FILL_W    = 5;

  localparam logic [7:0] TYPE_DATA = 8'h00;
  localparam logic [7:0] TYPE_EOF  = 8'h01;
  localparam logic [7:0] TYPE_ELA  = 8'h04;
  localparam logic [7:0] ELA_LEN   = 8'h02;

  localparam logic [6:0] ASCII_ZERO   = 7'd48;
  localparam logic [6:0] ASCII_A_BASE = 7'd55;

  // Records to send for one accepted item, plus their fixed fields.
  typedef struct packed {
    logic              ela;
    logic              data;
    logic              eof;
    logic [FILL_W-1:0] dlen;
    logic [15:0]       offset;
    logic [15:0]       page;
  } rec_plan_t;

  function automatic logic [6:0] hex_digit(input logic [3:0] v);
    hex_digit = (v < 4'd10) ? (ASCII_ZERO + {3'b000, v}) : (ASCII_A_BASE + {3'b000, v});
  endfunction

endpackage

FILE: sv/ihr_if.sv
// Channel interfaces: input data items and output record-byte items.
interface ihr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ihr_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] hex_high;
  logic [6:0] hex_low;
  logic       record_start;
  logic       record_end;
  logic       run_last;

  modport source (output valid, output hex_high, output hex_low, output record_start,
                  output record_end, output run_last, input ready);
  modport sink   (input valid, input hex_high, input hex_low, input record_start,
                  input record_end, input run_last, output ready);
endinterface

FILE: sv/ihr_record_buf.sv
// Record payload memory: one write port, one registered read port.
module ihr_record_buf import ihr_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [BUF_AW-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [BUF_AW-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/ihr_tracker.sv
// Address, page and fill bookkeeping; stores each item and plans the records.
module ihr_tracker import ihr_pkg::*; #(
  parameter int unsigned REC_LIMIT = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  ihr_in_if.sink            data,
  input  logic              emit_busy,
  output logic              wr_en,
  output logic [BUF_AW-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output logic              plan_valid,
  output rec_plan_t         plan
);

  logic [31:0]       start_address;
  logic              started;
  logic [31:0]       next_address;
  logic [15:0]       current_page;
  logic [FILL_W-1:0] fill_count;
  logic [15:0]       record_offset;

  logic              accept;
  logic [31:0]       addr_now;
  logic [FILL_W-1:0] fill_now;
  logic [FILL_W-1:0] fill_inc;
  logic [15:0]       page_now;
  logic [15:0]       offset_now;
  logic              opens;
  logic              need_ela;
  logic              closes;

  assign data.ready = !emit_busy;
  assign accept     = data.valid && data.ready;

  always_comb begin
    addr_now   = started ? next_address : start_address;
    fill_now   = started ? fill_count : '0;
    fill_inc   = fill_now + FILL_W'(1);
    page_now   = addr_now[31:16];
    opens      = (fill_now == '0);
    need_ela   = opens && (!started || (page_now != current_page));
    offset_now = opens ? addr_now[15:0] : record_offset;
    closes     = (fill_inc >= FILL_W'(REC_LIMIT)) || (addr_now[15:0] == 16'hFFFF)
                 || data.last_byte;
  end

  assign wr_en   = accept;
  assign wr_addr = fill_now[BUF_AW-1:0];
  assign wr_data = data.data_byte;

  assign plan_valid  = accept && (need_ela || closes);
  assign plan.ela    = need_ela;
  assign plan.data   = closes;
  assign plan.eof    = data.last_byte;
  assign plan.dlen   = fill_inc;
  assign plan.offset = offset_now;
  assign plan.page   = page_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= '0;
      started       <= 1'b0;
      next_address  <= '0;
      current_page  <= '0;
      fill_count    <= '0;
      record_offset <= '0;
    end else begin
      if (cfg_we) begin
        start_address <= cfg_wdata;
      end
      if (accept) begin
        started       <= !data.last_byte;
        next_address  <= addr_now + 32'd1;
        record_offset <= offset_now;
        fill_count    <= closes ? '0 : fill_inc;
        if (need_ela) begin
          current_page <= page_now;
        end
      end
    end
  end

endmodule

FILE: sv/ihr_emitter.sv
// Record sequencer: walks the planned records one byte per cycle into the output register while records is not stalled.
module ihr_emitter import ihr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              plan_valid,
  input  rec_plan_t         plan,
  output logic              busy,
  output logic [BUF_AW-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  ihr_out_if.source         records
);

  typedef enum logic [1:0] {KIND_ELA, KIND_DATA, KIND_EOF} kind_t;
  typedef enum logic [2:0] {PH_COUNT, PH_ADDR_HI, PH_ADDR_LO, PH_TYPE, PH_PAYLOAD,
                            PH_CHECK} phase_t;

  kind_t             kind;
  phase_t            phase;
  logic [BUF_AW-1:0] idx;
  logic [BUF_AW-1:0] idx_next;
  logic [7:0]        sum;
  logic              pend_data;
  logic              pend_eof;
  logic [FILL_W-1:0] dlen;
  logic [15:0]       offset;
  logic [15:0]       page;

  logic              advance;
  logic [FILL_W-1:0] cur_len;
  logic [15:0]       cur_addr;
  logic [7:0]        cur_type;
  logic [7:0]        byte_val;
  logic              final_byte;
  logic              pay_done;

  assign advance = busy && (!records.valid || records.ready);

  always_comb begin
    case (kind)
      KIND_ELA: begin
        cur_len  = FILL_W'(ELA_LEN);
        cur_addr = '0;
        cur_type = TYPE_ELA;
      end
      KIND_DATA: begin
        cur_len  = dlen;
        cur_addr = offset;
        cur_type = TYPE_DATA;
      end
      default: begin
        cur_len  = '0;
        cur_addr = '0;
        cur_type = TYPE_EOF;
      end
    endcase
  end

  assign pay_done = ({1'b0, idx} == (cur_len - FILL_W'(1)));

  always_comb begin
    case (phase)
      PH_COUNT:   byte_val = {{(8 - FILL_W){1'b0}}, cur_len};
      PH_ADDR_HI: byte_val = cur_addr[15:8];
      PH_ADDR_LO: byte_val = cur_addr[7:0];
      PH_TYPE:    byte_val = cur_type;
      PH_PAYLOAD: begin
        if (kind == KIND_ELA) begin
          byte_val = (idx == '0) ? page[15:8] : page[7:0];
        end else begin
          byte_val = rd_data;
        end
      end
      default:    byte_val = 8'h00 - sum;
    endcase
  end

  assign final_byte = (phase == PH_CHECK) && !pend_data && !pend_eof;

  // Read address follows the next index so read data is current once the index settles.
  always_comb begin
    idx_next = idx;
    if (advance) begin
      if (phase == PH_TYPE) begin
        idx_next = '0;
      end else if (phase == PH_PAYLOAD) begin
        idx_next = idx + BUF_AW'(1);
      end
    end
  end

  assign rd_addr = idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      phase         <= PH_COUNT;
      kind          <= KIND_ELA;
      pend_data     <= 1'b0;
      pend_eof      <= 1'b0;
      idx           <= '0;
      records.valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (advance) begin
        records.valid        <= 1'b1;
        records.hex_high     <= hex_digit(byte_val[7:4]);
        records.hex_low      <= hex_digit(byte_val[3:0]);
        records.record_start <= (phase == PH_COUNT);
        records.record_end   <= (phase == PH_CHECK);
        records.run_last     <= final_byte;
        sum <= (phase == PH_COUNT) ? byte_val : sum + byte_val;
        case (phase)
          PH_COUNT:   phase <= PH_ADDR_HI;
          PH_ADDR_HI: phase <= PH_ADDR_LO;
          PH_ADDR_LO: phase <= PH_TYPE;
          PH_TYPE:    phase <= (cur_len == '0) ? PH_CHECK : PH_PAYLOAD;
          PH_PAYLOAD: begin
            if (pay_done) begin
              phase <= PH_CHECK;
            end
          end
          default: begin
            phase <= PH_COUNT;
            if (pend_data) begin
              kind      <= KIND_DATA;
              pend_data <= 1'b0;
            end else if (pend_eof) begin
              kind     <= KIND_EOF;
              pend_eof <= 1'b0;
            end else begin
              busy <= 1'b0;
            end
          end
        endcase
      end else if (records.ready) begin
        records.valid <= 1'b0;
      end

      if (plan_valid) begin
        busy      <= 1'b1;
        phase     <= PH_COUNT;
        kind      <= plan.ela ? KIND_ELA : KIND_DATA;
        pend_data <= plan.ela && plan.data;
        pend_eof  <= plan.eof;
        dlen      <= plan.dlen;
        offset    <= plan.offset;
        page      <= plan.page;
      end
    end
  end

endmodule

FILE: sv/intel_hex_record_encoder.sv
// Top level of the Intel HEX record encoder (32-bit linear addressing).
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+-------------------------------------------------
//  data      | in  | valid/ready   | data_byte[7:0], last_byte
//  records   | out | valid/ready   | hex_high[6:0], hex_low[6:0], record_start,
//            |     |               | record_end, run_last
//  cfg       | in  | cfg_we        | cfg_wdata[31:0] = start_address
//
// An item that causes no records does not hold data.ready low. An item that
// causes records holds data.ready low while the output sequencer sends their
// bytes (7 for an address record, 5 + length for a data record, 5 for end of
// file); the sequencer emits one record byte per cycle unless records stalls.
// A stall on records holds the sequencer; the output register keeps its item.
// Reset is synchronous and clears all control state; no clearing pass is needed.
module intel_hex_record_encoder import ihr_pkg::*; #(
  parameter int RECORD_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  ihr_in_if.sink      data,
  ihr_out_if.source   records
);

  localparam int unsigned REC_LIMIT =
    (RECORD_BYTES < 1) ? 1 :
    (RECORD_BYTES > int'(BUF_DEPTH)) ? BUF_DEPTH : RECORD_BYTES;

  logic              emit_busy;
  logic              wr_en;
  logic [BUF_AW-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [BUF_AW-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              plan_valid;
  rec_plan_t         plan;

  ihr_tracker #(.REC_LIMIT(REC_LIMIT)) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .data       (data),
    .emit_busy  (emit_busy),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .plan_valid (plan_valid),
    .plan       (plan)
  );

  ihr_record_buf u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ihr_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .plan_valid (plan_valid),
    .plan       (plan),
    .busy       (emit_busy),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .records    (records)
  );

endmodule

FILE: sv/ihr_checker.sv
// Port-level assertions for the Intel HEX record encoder, and their bind.
module ihr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] hex_high,
  input logic [6:0] hex_low,
  input logic       record_start,
  input logic       record_end,
  input logic       run_last
);

  // A record cannot open and close on the same byte.
  a_start_end_apart: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(record_start && record_end))
    else $error("record_start and record_end on the same item");

  // The final item of a run always closes a record.
  a_run_last_closes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && run_last) |-> record_end)
    else $error("run_last on an item that does not close a record");

  // Byte count never exceeds 16, so its upper digit is 0 or 1.
  a_count_digit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && record_start) |-> (hex_high == 7'd48 || hex_high == 7'd49))
    else $error("byte count digit out of range");

  // Hold a stalled item.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(hex_high) && $stable(hex_low)
      && $stable(record_start) && $stable(record_end) && $stable(run_last)))
    else $error("stalled output item changed");

endmodule

bind intel_hex_record_encoder ihr_checker u_ihr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (records.valid),
  .out_ready    (records.ready),
  .hex_high     (records.hex_high),
  .hex_low      (records.hex_low),
  .record_start (records.record_start),
  .record_end   (records.record_end),
  .run_last     (records.run_last)
);
